// File: rtl/core/sabp_pkg.sv
// shared types and constants of the scaled alpha blit pixel core
`default_nettype none
package sabp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegSourceWidth  = 3'd0,
    RegSourceHeight = 3'd1,
    RegTargetLeft   = 3'd2,
    RegTargetTop    = 3'd3,
    RegTargetWidth  = 3'd4,
    RegTargetHeight = 3'd5,
    RegLayerOpacity = 3'd6,
    RegOpaqueMode   = 3'd7
  } cfg_reg_e;

  // operation codes
  typedef enum logic {
    OpMap   = 1'b0,
    OpBlend = 1'b1
  } op_e;

  localparam int unsigned DivBits    = 12;
  localparam int unsigned NumStages  = 16;
  localparam int unsigned FrontDepth = 4;
  localparam int unsigned OutDepth   = 32;

  typedef struct packed {
    logic [11:0]        source_width;
    logic [11:0]        source_height;
    logic signed [12:0] target_left;
    logic signed [12:0] target_top;
    logic [11:0]        target_width;
    logic [11:0]        target_height;
    logic [7:0]         layer_opacity;
    logic               opaque_mode;
  } cfg_t;

  // classified word between front and back
  typedef struct packed {
    op_e         op;
    logic        in_rect;
    logic [11:0] ox;
    logic [11:0] oy;
    logic [31:0] srgba;
    logic [23:0] drgb;
  } item_t;

  // one pipeline stage of the back part
  typedef struct packed {
    op_e         op;
    logic        in_rect;
    logic [23:0] rx;
    logic [23:0] ry;
    logic [11:0] qx;
    logic [11:0] qy;
    logic [31:0] srgba;
    logic [23:0] drgb;
    logic [15:0] av;
    logic [7:0]  a;
    logic [7:0]  cr;
    logic [7:0]  cg;
    logic [7:0]  cb;
    logic        we;
    logic [23:0] rgb;
    logic [23:0] prod;
    logic [25:0] off;
  } stage_t;

  typedef struct packed {
    logic        inside_res;
    logic [11:0] src_col;
    logic [11:0] src_row;
    logic [25:0] src_byte_offset;
    logic        write_enable;
    logic [23:0] result_rgb;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/scaled_alpha_blit_pixel_core.sv
// top level: configuration registers, front and back parts
// throughput: one item per cycle, set by the 16-stage divider and blend pipeline,
// but the back part admits a word only while the 32-entry result queue has room
// reset: asynchronous active low, registers return to their reset values,
// queues and pipeline are empty
`default_nettype none
module scaled_alpha_blit_pixel_core #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 288
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        op_i,
  input  wire logic [11:0] dest_col_i,
  input  wire logic [11:0] dest_row_i,
  input  wire logic [31:0] source_rgba_i,
  input  wire logic [23:0] dest_rgb_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             inside_res_o,
  output logic [11:0]      src_col_o,
  output logic [11:0]      src_row_o,
  output logic [25:0]      src_byte_offset_o,
  output logic             write_enable_o,
  output logic [23:0]      result_rgb_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  sabp_pkg::cfg_t    cfg_q;
  sabp_pkg::item_t   item;
  sabp_pkg::result_t res;
  logic              item_valid, item_pop;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= 12'd1;
      cfg_q.source_height <= 12'd1;
      cfg_q.target_left   <= 13'sd0;
      cfg_q.target_top    <= 13'sd0;
      cfg_q.target_width  <= 12'd1;
      cfg_q.target_height <= 12'd1;
      cfg_q.layer_opacity <= 8'd255;
      cfg_q.opaque_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sabp_pkg::cfg_reg_e'(cfg_index_i))
        sabp_pkg::RegSourceWidth:  cfg_q.source_width  <= cfg_data_i[11:0];
        sabp_pkg::RegSourceHeight: cfg_q.source_height <= cfg_data_i[11:0];
        sabp_pkg::RegTargetLeft:   cfg_q.target_left   <= $signed(cfg_data_i);
        sabp_pkg::RegTargetTop:    cfg_q.target_top    <= $signed(cfg_data_i);
        sabp_pkg::RegTargetWidth:  cfg_q.target_width  <= cfg_data_i[11:0];
        sabp_pkg::RegTargetHeight: cfg_q.target_height <= cfg_data_i[11:0];
        sabp_pkg::RegLayerOpacity: cfg_q.layer_opacity <= cfg_data_i[7:0];
        sabp_pkg::RegOpaqueMode:   cfg_q.opaque_mode   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front part
  sabp_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .op_i         (op_i),
    .dest_col_i   (dest_col_i),
    .dest_row_i   (dest_row_i),
    .source_rgba_i(source_rgba_i),
    .dest_rgb_i   (dest_rgb_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // back part
  sabp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (res)
  );

  assign inside_res_o      = res.inside_res;
  assign src_col_o         = res.src_col;
  assign src_row_o         = res.src_row;
  assign src_byte_offset_o = res.src_byte_offset;
  assign write_enable_o    = res.write_enable;
  assign result_rgb_o      = res.result_rgb;

endmodule
`default_nettype wire

// File: rtl/core/sabp_front.sv
// front part: clips map items and queues classified words for the back part
`default_nettype none
module sabp_front #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 288
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sabp_pkg::cfg_t cfg_i,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire logic           op_i,
  input  wire logic [11:0]    dest_col_i,
  input  wire logic [11:0]    dest_row_i,
  input  wire logic [31:0]    source_rgba_i,
  input  wire logic [23:0]    dest_rgb_i,
  output logic                item_valid_o,
  output sabp_pkg::item_t     item_o,
  input  wire logic           item_pop_i
);

  localparam int unsigned PtrW = $clog2(sabp_pkg::FrontDepth);
  localparam int unsigned CntW = $clog2(sabp_pkg::FrontDepth + 1);
  localparam logic signed [14:0] ScrW = 15'(SCREEN_WIDTH);
  localparam logic signed [14:0] ScrH = 15'(SCREEN_HEIGHT);

  logic signed [14:0] x, y, dx, dy, x0, y0, xe, ye, x1, y1, ox, oy;
  logic               sizes_ok, in_rect;
  sabp_pkg::item_t    word;
  sabp_pkg::item_t    q_mem [sabp_pkg::FrontDepth];
  logic [PtrW-1:0]    wptr_q, rptr_q;
  logic [CntW-1:0]    cnt_q;
  logic               wr, rd;

  // clip against target rectangle and screen
  always_comb begin
    x  = $signed({3'b000, dest_col_i});
    y  = $signed({3'b000, dest_row_i});
    dx = {{2{cfg_i.target_left[12]}}, cfg_i.target_left};
    dy = {{2{cfg_i.target_top[12]}}, cfg_i.target_top};
    x0 = (dx < 15'sd0) ? 15'sd0 : dx;
    y0 = (dy < 15'sd0) ? 15'sd0 : dy;
    xe = dx + $signed({3'b000, cfg_i.target_width});
    ye = dy + $signed({3'b000, cfg_i.target_height});
    x1 = (xe < ScrW) ? xe : ScrW;
    y1 = (ye < ScrH) ? ye : ScrH;
    ox = x - dx;
    oy = y - dy;
    sizes_ok = (cfg_i.source_width != '0) && (cfg_i.source_height != '0) &&
               (cfg_i.target_width != '0) && (cfg_i.target_height != '0);
    in_rect = sizes_ok && (x >= x0) && (x < x1) && (y >= y0) && (y < y1);
    word.op      = sabp_pkg::op_e'(op_i);
    word.in_rect = in_rect;
    word.ox      = ox[11:0];
    word.oy      = oy[11:0];
    word.srgba   = source_rgba_i;
    word.drgb    = dest_rgb_i;
  end

  // classified word queue
  assign full_o       = (cnt_q == CntW'(sabp_pkg::FrontDepth));
  assign wr           = push_i && !full_o;
  assign item_valid_o = (cnt_q != '0);
  assign rd           = item_pop_i && item_valid_o;
  assign item_o       = q_mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_mem[wptr_q] <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(wr) - CntW'(rd);
    end
  end

  // queue sanity
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> item_valid_o) else $error("front queue popped while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(sabp_pkg::FrontDepth)) else $error("front queue overflow");

endmodule
`default_nettype wire

// File: rtl/core/sabp_back.sv
// back part: divider and blend pipeline with result queue
`default_nettype none
module sabp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sabp_pkg::cfg_t cfg_i,
  input  wire logic           item_valid_i,
  input  wire sabp_pkg::item_t item_i,
  output logic                item_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output sabp_pkg::result_t   result_o
);

  localparam int unsigned NS   = sabp_pkg::NumStages;
  localparam int unsigned DB   = sabp_pkg::DivBits;
  localparam int unsigned PtrW = $clog2(sabp_pkg::OutDepth);
  localparam int unsigned CntW = $clog2(sabp_pkg::OutDepth + 1);

  sabp_pkg::stage_t  st_d [NS];
  sabp_pkg::stage_t  st_q [NS];
  logic [NS-1:0]     vld_q;
  logic [CntW-1:0]   occ_q, ocnt_q;
  logic [PtrW-1:0]   wptr_q, rptr_q;
  sabp_pkg::result_t o_mem [sabp_pkg::OutDepth];
  sabp_pkg::result_t res;
  logic              take, opop;

  // admit a word only when its result has a guaranteed slot
  assign take       = item_valid_i && (occ_q < CntW'(sabp_pkg::OutDepth));
  assign item_pop_o = take;

  // pipeline stages
  always_comb begin
    logic [23:0] dvx, dvy;
    logic [16:0] at;
    logic [7:0]  ia;
    logic [15:0] sr, sg, sb;
    logic [11:0] cx, cy;
    logic [23:0] sum;
    dvx = '0; dvy = '0; at = '0; ia = '0; sr = '0; sg = '0; sb = '0;
    cx = '0; cy = '0; sum = '0;
    st_d[0]         = '0;
    st_d[0].op      = item_i.op;
    st_d[0].in_rect = item_i.in_rect;
    st_d[0].rx      = {12'd0, item_i.ox};
    st_d[0].ry      = {12'd0, item_i.oy};
    st_d[0].srgba   = item_i.srgba;
    st_d[0].drgb    = item_i.drgb;
    // scaled offsets and alpha product
    st_d[1]    = st_q[0];
    st_d[1].rx = st_q[0].rx[11:0] * cfg_i.source_width;
    st_d[1].ry = st_q[0].ry[11:0] * cfg_i.source_height;
    st_d[1].av = st_q[0].srgba[31:24] * cfg_i.layer_opacity;
    // one quotient bit per stage, blend alongside
    for (int k = 2; k < DB + 2; k++) begin
      st_d[k] = st_q[k-1];
      dvx = {12'd0, cfg_i.target_width} << (DB + 1 - k);
      dvy = {12'd0, cfg_i.target_height} << (DB + 1 - k);
      if (st_q[k-1].rx >= dvx) begin
        st_d[k].rx = st_q[k-1].rx - dvx;
        st_d[k].qx[DB + 1 - k] = 1'b1;
      end
      if (st_q[k-1].ry >= dvy) begin
        st_d[k].ry = st_q[k-1].ry - dvy;
        st_d[k].qy[DB + 1 - k] = 1'b1;
      end
      if (k == 2) begin
        at = {1'b0, st_q[k-1].av} + {9'd0, st_q[k-1].av[15:8]} + 17'd1;
        st_d[k].a = at[15:8];
      end
      if (k == 3) begin
        ia = 8'd255 - st_q[k-1].a;
        sr = st_q[k-1].srgba[7:0] * st_q[k-1].a + st_q[k-1].drgb[23:16] * ia;
        sg = st_q[k-1].srgba[15:8] * st_q[k-1].a + st_q[k-1].drgb[15:8] * ia;
        sb = st_q[k-1].srgba[23:16] * st_q[k-1].a + st_q[k-1].drgb[7:0] * ia;
        st_d[k].cr = sr[15:8];
        st_d[k].cg = sg[15:8];
        st_d[k].cb = sb[15:8];
      end
      if (k == 4) begin
        if (st_q[k-1].op == sabp_pkg::OpMap) begin
          st_d[k].we  = 1'b0;
          st_d[k].rgb = '0;
        end else if (cfg_i.opaque_mode) begin
          st_d[k].we  = 1'b1;
          st_d[k].rgb = {st_q[k-1].srgba[7:0], st_q[k-1].srgba[15:8],
                         st_q[k-1].srgba[23:16]};
        end else if (st_q[k-1].a == 8'd0) begin
          st_d[k].we  = 1'b0;
          st_d[k].rgb = st_q[k-1].drgb;
        end else begin
          st_d[k].we  = 1'b1;
          st_d[k].rgb = {st_q[k-1].cr, st_q[k-1].cg, st_q[k-1].cb};
        end
      end
    end
    // clamp and row product
    st_d[DB+2] = st_q[DB+1];
    cx = (st_q[DB+1].qx >= cfg_i.source_width) ? cfg_i.source_width - 12'd1
                                               : st_q[DB+1].qx;
    cy = (st_q[DB+1].qy >= cfg_i.source_height) ? cfg_i.source_height - 12'd1
                                                : st_q[DB+1].qy;
    st_d[DB+2].qx   = cx;
    st_d[DB+2].qy   = cy;
    st_d[DB+2].prod = cy * cfg_i.source_width;
    // byte offset
    st_d[DB+3]     = st_q[DB+2];
    sum            = st_q[DB+2].prod + {12'd0, st_q[DB+2].qx};
    st_d[DB+3].off = {sum, 2'b00};
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], take};
    end
  end

  // result word from the last stage
  always_comb begin
    res = '0;
    if (st_q[NS-1].op == sabp_pkg::OpMap) begin
      if (st_q[NS-1].in_rect) begin
        res.inside_res      = 1'b1;
        res.src_col         = st_q[NS-1].qx;
        res.src_row         = st_q[NS-1].qy;
        res.src_byte_offset = st_q[NS-1].off;
      end
    end else begin
      res.write_enable = st_q[NS-1].we;
      res.result_rgb   = st_q[NS-1].rgb;
    end
  end

  // result queue
  assign empty_o  = (ocnt_q == '0);
  assign opop     = pop_i && !empty_o;
  assign result_o = o_mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (vld_q[NS-1]) begin
      o_mem[wptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      ocnt_q <= '0;
      occ_q  <= '0;
    end else begin
      if (vld_q[NS-1]) wptr_q <= wptr_q + 1'b1;
      if (opop) rptr_q <= rptr_q + 1'b1;
      ocnt_q <= ocnt_q + CntW'(vld_q[NS-1]) - CntW'(opop);
      occ_q  <= occ_q + CntW'(take) - CntW'(opop);
    end
  end

  // occupancy bookkeeping
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(sabp_pkg::OutDepth)) else $error("occupancy above queue depth");
  a_occ_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q + CntW'($countones(vld_q)) == occ_q) else $error("occupancy mismatch");
  a_map_no_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-1] && st_q[NS-1].op == sabp_pkg::OpMap) |-> !res.write_enable)
    else $error("map word with write enable");

endmodule
`default_nettype wire

// File: tb/scaled_alpha_blit_pixel_core_tb.sv
// testbench of the scaled alpha blit pixel core: directed and random map and blend words
`default_nettype none
module scaled_alpha_blit_pixel_core_tb;

  localparam int ScreenW = 640;
  localparam int ScreenH = 288;
  localparam int DrainCycles = 40;
  localparam longint CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        op_i;
  logic [11:0] dest_col_i;
  logic [11:0] dest_row_i;
  logic [31:0] source_rgba_i;
  logic [23:0] dest_rgb_i;
  logic        empty;
  logic        pop;
  logic        inside_res_o;
  logic [11:0] src_col_o;
  logic [11:0] src_row_o;
  logic [25:0] src_byte_offset_o;
  logic        write_enable_o;
  logic [23:0] result_rgb_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index_i;
  logic [12:0] cfg_data_i;

  // predictor copy of the configuration
  sabp_pkg::cfg_t    shadow_cfg;
  sabp_pkg::result_t pending_pixels[$];
  int      mismatch_count;
  int      push_idle_pct;
  int      pop_idle_pct;
  longint  cycle_count;

  scaled_alpha_blit_pixel_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .op_i(op_i),
    .dest_col_i(dest_col_i), .dest_row_i(dest_row_i), .source_rgba_i(source_rgba_i),
    .dest_rgb_i(dest_rgb_i), .empty(empty), .pop(pop), .inside_res_o(inside_res_o),
    .src_col_o(src_col_o), .src_row_o(src_row_o), .src_byte_offset_o(src_byte_offset_o),
    .write_enable_o(write_enable_o), .result_rgb_o(result_rgb_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // work out the pixel result of one word
  function automatic sabp_pkg::result_t predict_pixel(sabp_pkg::op_e op, logic [11:0] col,
                                                      logic [11:0] row, logic [31:0] srgba,
                                                      logic [23:0] drgb);
    sabp_pkg::result_t r;
    longint dx, dy, x0, y0, x1, y1, sx, sy;
    int av, a, ia, cr, cg, cb;
    r = '0;
    if (op == sabp_pkg::OpMap) begin
      dx = longint'(shadow_cfg.target_left);
      dy = longint'(shadow_cfg.target_top);
      x0 = (dx > 0) ? dx : 0;
      y0 = (dy > 0) ? dy : 0;
      x1 = dx + shadow_cfg.target_width;
      if (x1 > ScreenW) x1 = ScreenW;
      y1 = dy + shadow_cfg.target_height;
      if (y1 > ScreenH) y1 = ScreenH;
      if (shadow_cfg.source_width != 0 && shadow_cfg.source_height != 0 &&
          shadow_cfg.target_width != 0 && shadow_cfg.target_height != 0 &&
          longint'(col) >= x0 && longint'(col) < x1 &&
          longint'(row) >= y0 && longint'(row) < y1) begin
        sx = (longint'(col) - dx) * shadow_cfg.source_width / shadow_cfg.target_width;
        sy = (longint'(row) - dy) * shadow_cfg.source_height / shadow_cfg.target_height;
        if (sx >= shadow_cfg.source_width) sx = shadow_cfg.source_width - 1;
        if (sy >= shadow_cfg.source_height) sy = shadow_cfg.source_height - 1;
        r.inside_res = 1'b1;
        r.src_col = sx[11:0];
        r.src_row = sy[11:0];
        r.src_byte_offset = 26'((sy * shadow_cfg.source_width + sx) * 4);
      end
    end else if (shadow_cfg.opaque_mode) begin
      r.write_enable = 1'b1;
      r.result_rgb = {srgba[7:0], srgba[15:8], srgba[23:16]};
    end else begin
      av = srgba[31:24] * shadow_cfg.layer_opacity;
      a = (av + (av >> 8) + 1) >> 8;
      if (a == 0) begin
        r.result_rgb = drgb;
      end else begin
        ia = 255 - a;
        cr = (srgba[7:0] * a + drgb[23:16] * ia) >> 8;
        cg = (srgba[15:8] * a + drgb[15:8] * ia) >> 8;
        cb = (srgba[23:16] * a + drgb[7:0] * ia) >> 8;
        r.write_enable = 1'b1;
        r.result_rgb = {cr[7:0], cg[7:0], cb[7:0]};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  // send one word, with random idling before it
  task automatic send_word(sabp_pkg::op_e op, logic [11:0] col, logic [11:0] row,
                           logic [31:0] srgba, logic [23:0] drgb);
    while ($urandom_range(99, 0) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    dest_col_i <= col;
    dest_row_i <= row;
    source_rgba_i <= srgba;
    dest_rgb_i <= drgb;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_pixels.push_back(predict_pixel(op, col, row, srgba, drgb));
  endtask

  task automatic send_random_word();
    logic [11:0] col, row;
    if ($urandom_range(3, 0) != 0) begin
      col = 12'($urandom_range(ScreenW + 40, 0));
      row = 12'($urandom_range(ScreenH + 40, 0));
    end else begin
      col = 12'($urandom);
      row = 12'($urandom);
    end
    send_word(sabp_pkg::op_e'($urandom_range(1, 0)), col, row, $urandom, 24'($urandom));
  endtask

  // stop sending, wait for all results, then for the pipeline to settle
  task automatic drain();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(sabp_pkg::cfg_reg_e idx, logic [12:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      sabp_pkg::RegSourceWidth:  shadow_cfg.source_width = value[11:0];
      sabp_pkg::RegSourceHeight: shadow_cfg.source_height = value[11:0];
      sabp_pkg::RegTargetLeft:   shadow_cfg.target_left = value;
      sabp_pkg::RegTargetTop:    shadow_cfg.target_top = value;
      sabp_pkg::RegTargetWidth:  shadow_cfg.target_width = value[11:0];
      sabp_pkg::RegTargetHeight: shadow_cfg.target_height = value[11:0];
      sabp_pkg::RegLayerOpacity: shadow_cfg.layer_opacity = value[7:0];
      default:                   shadow_cfg.opaque_mode = value[0];
    endcase
  endtask

  task automatic set_geometry(int sw, int sh, int tl, int tt, int tw, int th);
    write_reg(sabp_pkg::RegSourceWidth, 13'(sw));
    write_reg(sabp_pkg::RegSourceHeight, 13'(sh));
    write_reg(sabp_pkg::RegTargetLeft, 13'(tl));
    write_reg(sabp_pkg::RegTargetTop, 13'(tt));
    write_reg(sabp_pkg::RegTargetWidth, 13'(tw));
    write_reg(sabp_pkg::RegTargetHeight, 13'(th));
  endtask

  // directed words at the reset setting, then the field extremes
  task automatic test_directed();
    send_word(sabp_pkg::OpMap, 12'd0, 12'd0, '0, '0);
    send_word(sabp_pkg::OpMap, 12'd1, 12'd0, '0, '0);
    set_geometry(4095, 4095, -20, -10, 4095, 4095);
    write_reg(sabp_pkg::RegLayerOpacity, 13'd255);
    write_reg(sabp_pkg::RegOpaqueMode, 13'd0);
    send_word(sabp_pkg::OpMap, 12'd0, 12'd0, '0, '0);
    send_word(sabp_pkg::OpMap, 12'd639, 12'd287, '0, '0);
    send_word(sabp_pkg::OpMap, 12'd640, 12'd0, '0, '0);
    send_word(sabp_pkg::OpMap, 12'hfff, 12'hfff, 32'hffffffff, 24'hffffff);
    send_word(sabp_pkg::OpBlend, 12'hfff, 12'hfff, 32'hffffffff, 24'h000000);
    send_word(sabp_pkg::OpBlend, 12'd0, 12'd0, 32'h00123456, 24'habcdef);
    send_word(sabp_pkg::OpBlend, 12'd0, 12'd0, 32'h80ff00ff, 24'hffffff);
    send_word(sabp_pkg::OpBlend, 12'd0, 12'd0, 32'h01ffffff, 24'h000000);
    drain();
    // zero sizes and a rectangle off screen
    set_geometry(0, 5, 0, 0, 10, 10);
    send_word(sabp_pkg::OpMap, 12'd3, 12'd3, '0, '0);
    set_geometry(5, 5, 0, 0, 0, 10);
    send_word(sabp_pkg::OpMap, 12'd3, 12'd3, '0, '0);
    set_geometry(5, 5, 700, -4096, 100, 100);
    send_word(sabp_pkg::OpMap, 12'd701, 12'd0, '0, '0);
    set_geometry(1, 1, 4095, 4095, 1, 1);
    send_word(sabp_pkg::OpMap, 12'd4095, 12'd4095, '0, '0);
    // zero opacity and opaque copy
    write_reg(sabp_pkg::RegLayerOpacity, 13'd0);
    send_word(sabp_pkg::OpBlend, 12'd0, 12'd0, 32'hff112233, 24'h445566);
    write_reg(sabp_pkg::RegOpaqueMode, 13'd1);
    send_word(sabp_pkg::OpBlend, 12'd0, 12'd0, 32'h00112233, 24'h445566);
    send_word(sabp_pkg::OpBlend, 12'd0, 12'd0, 32'hffffffff, 24'h000000);
    drain();
  endtask

  // random words under a random setting
  task automatic test_random_phase(int words);
    set_geometry($urandom_range(4095, 0), $urandom_range(4095, 0),
                 $urandom_range(700, 0) - 60, $urandom_range(340, 0) - 60,
                 $urandom_range(700, 0), $urandom_range(400, 0));
    if ($urandom_range(3, 0) == 0) begin
      set_geometry($urandom_range(4095, 1), $urandom_range(4095, 1),
                   -4096 + $urandom_range(8191, 0), -4096 + $urandom_range(8191, 0),
                   $urandom_range(4095, 1), $urandom_range(4095, 1));
    end
    write_reg(sabp_pkg::RegLayerOpacity, 13'($urandom_range(255, 0)));
    write_reg(sabp_pkg::RegOpaqueMode, 13'($urandom_range(3, 0) == 0));
    repeat (words) send_random_word();
    drain();
  endtask

  task automatic test_idle_pattern(int sender_pct, int receiver_pct);
    push_idle_pct = sender_pct;
    pop_idle_pct = receiver_pct;
    repeat (6) test_random_phase(95);
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    sabp_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (inside_res_o !== want.inside_res)
          report_mismatch("inside_res", inside_res_o, want.inside_res);
        if (src_col_o !== want.src_col) report_mismatch("src_col", src_col_o, want.src_col);
        if (src_row_o !== want.src_row) report_mismatch("src_row", src_row_o, want.src_row);
        if (src_byte_offset_o !== want.src_byte_offset)
          report_mismatch("src_byte_offset", src_byte_offset_o, want.src_byte_offset);
        if (write_enable_o !== want.write_enable)
          report_mismatch("write_enable", write_enable_o, want.write_enable);
        if (result_rgb_o !== want.result_rgb)
          report_mismatch("result_rgb", result_rgb_o, want.result_rgb);
      end
    end
    pop <= ($urandom_range(99, 0) >= pop_idle_pct);
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    op_i = 1'b0;
    dest_col_i = '0;
    dest_row_i = '0;
    source_rgba_i = '0;
    dest_rgb_i = '0;
    cfg_valid = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    cycle_count = 0;
    mismatch_count = 0;
    push_idle_pct = 0;
    pop_idle_pct = 0;
    shadow_cfg = '{source_width: 12'd1, source_height: 12'd1, target_left: 13'sd0,
                   target_top: 13'sd0, target_width: 12'd1, target_height: 12'd1,
                   layer_opacity: 8'd255, opaque_mode: 1'b0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_pattern(16, 61);
    test_idle_pattern(61, 16);
    test_idle_pattern(0, 0);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
